// File: hdl/datetime_add_seconds_unit_assert.svh
// assertion macros for the date and time adder
`ifndef DATETIME_ADD_SECONDS_UNIT_ASSERT_SVH
`define DATETIME_ADD_SECONDS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, clocked on clk, off while in reset
`define DTAS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("datetime_add_seconds_unit: assertion failed");

// next-cycle implication, clocked on clk, off while in reset
`define DTAS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("datetime_add_seconds_unit: assertion failed");

`else

`define DTAS_ASSERT_IMP(lbl, ante, cons)
`define DTAS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: hdl/dtas_pkg.sv
`default_nettype none

package dtas_pkg;

  localparam int TOD_W  = 17;
  localparam int T_W    = 34;
  localparam int YEAR_W = 17;
  localparam int YMOD_W = 9;
  localparam int K_W    = 3;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int YEAR_CYCLE    = 400;

  localparam logic [31:0] MAX_YEAR = 32'd65535;

  localparam logic [K_W-1:0] MOD_K_FIRST  = K_W'(7);
  localparam logic [K_W-1:0] HOUR_K_FIRST = K_W'(4);
  localparam logic [K_W-1:0] MIN_K_FIRST  = K_W'(5);

  localparam logic [YMOD_W-1:0] YMOD_LAST = YMOD_W'(YEAR_CYCLE - 1);
  localparam logic [YMOD_W-1:0] YMOD_C100 = YMOD_W'(100);
  localparam logic [YMOD_W-1:0] YMOD_C200 = YMOD_W'(200);
  localparam logic [YMOD_W-1:0] YMOD_C300 = YMOD_W'(300);

  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MOD,
    ST_DAY,
    ST_HOUR,
    ST_MIN,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic load;
    logic mod_load;
    logic fwd;
    logic back;
  } cal_ctrl_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [31:0] offset_seconds;
    logic [5:0]  start_second;
    logic [5:0]  start_minute;
    logic [4:0]  start_hour;
    logic [15:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
  } in_data_t;

  typedef struct packed {
    logic [5:0]  pad;
    logic [5:0]  result_second;
    logic [5:0]  result_minute;
    logic [4:0]  result_hour;
    logic [15:0] result_year;
    logic [3:0]  result_month;
    logic [4:0]  result_day;
  } out_data_t;

  function automatic logic [4:0] month_len(logic [3:0] month, logic leap);
    logic [4:0] len;
    unique case (month) inside
      MON_FEB:                            len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default:                            len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: hdl/datetime_add_seconds_unit.sv
// sequence: after an input transfer the states SUM, MOD, DAY, HOUR, MIN and DONE run in
// order, DAY repeating once per whole day stepped; one shared 34-bit adder does the offset
// sum and the mod, day, hour and minute steps; in_tready is high only when idle,
// also while a finished result still waits in the output register
// reset: synchronous active-low rst_n clears the sequencer and out_tvalid; no clearing pass
`default_nettype none
`include "datetime_add_seconds_unit_assert.svh"

module datetime_add_seconds_unit #(
  parameter logic [31:0] MAX_YEAR = dtas_pkg::MAX_YEAR
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // start_day, start_month, start_year, start_hour, start_minute, start_second,
  // offset_seconds
  input  wire logic [79:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // result_day, result_month, result_year, result_hour, result_minute, result_second
  output logic      [47:0] out_tdata
);

  localparam int T_W    = dtas_pkg::T_W;
  localparam int TOD_W  = dtas_pkg::TOD_W;
  localparam int K_W    = dtas_pkg::K_W;

  dtas_pkg::st_t       state_r, state_nxt;
  dtas_pkg::in_data_t  in_data;
  dtas_pkg::out_data_t out_data;
  dtas_pkg::cal_ctrl_t cal_ctrl;

  logic [K_W-1:0]   k_r, k_nxt;
  logic [T_W-1:0]   t_r, t_nxt;
  logic [31:0]      off_r, off_nxt;
  logic [TOD_W-1:0] work_r, work_nxt;
  logic [4:0]       hour_r, hour_nxt;
  logic [5:0]       min_r, min_nxt;
  logic             out_tvalid_r;
  logic [47:0]      out_tdata_r;
  logic             out_load;

  logic [T_W-1:0]   alu_a, alu_b, alu_sum;
  logic             alu_sub, alu_neg;
  logic [TOD_W-1:0] tod0;

  logic [4:0]       cal_day;
  logic [3:0]       cal_month;
  logic [15:0]      cal_year;

  assign in_data   = dtas_pkg::in_data_t'(in_tdata);
  assign in_tready = (state_r == dtas_pkg::ST_IDLE);

  assign tod0 = TOD_W'(in_data.start_hour) * TOD_W'(dtas_pkg::SECS_PER_HOUR) +
                TOD_W'(in_data.start_minute) * TOD_W'(dtas_pkg::SECS_PER_MIN) +
                TOD_W'(in_data.start_second);

  dtas_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum),
    .neg (alu_neg)
  );

  dtas_cal #(
    .MAX_YEAR (MAX_YEAR)
  ) u_cal (
    .clk         (clk),
    .ctrl        (cal_ctrl),
    .start_day   (in_data.start_day),
    .start_month (in_data.start_month),
    .start_year  (in_data.start_year),
    .mod_val     (work_nxt[dtas_pkg::YMOD_W-1:0]),
    .day         (cal_day),
    .month       (cal_month),
    .year        (cal_year)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dtas_pkg::ST_IDLE: if (in_tvalid) state_nxt = dtas_pkg::ST_SUM;
      dtas_pkg::ST_SUM:  state_nxt = dtas_pkg::ST_MOD;
      dtas_pkg::ST_MOD:  if (k_r == '0) state_nxt = dtas_pkg::ST_DAY;
      dtas_pkg::ST_DAY:  if (!t_r[T_W-1] && alu_neg) state_nxt = dtas_pkg::ST_HOUR;
      dtas_pkg::ST_HOUR: if (k_r == '0) state_nxt = dtas_pkg::ST_MIN;
      dtas_pkg::ST_MIN:  if (k_r == '0) state_nxt = dtas_pkg::ST_DONE;
      dtas_pkg::ST_DONE: if (!out_tvalid_r || out_tready) state_nxt = dtas_pkg::ST_IDLE;
      default:           state_nxt = dtas_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    t_nxt    = t_r;
    off_nxt  = off_r;
    work_nxt = work_r;
    k_nxt    = k_r;
    hour_nxt = hour_r;
    min_nxt  = min_r;
    alu_a    = t_r;
    alu_b    = '0;
    alu_sub  = 1'b0;
    cal_ctrl = '0;
    out_load = 1'b0;
    unique case (state_r)
      dtas_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          t_nxt         = T_W'(tod0);
          off_nxt       = in_data.offset_seconds;
          work_nxt      = TOD_W'(in_data.start_year);
          k_nxt         = dtas_pkg::MOD_K_FIRST;
          cal_ctrl.load = 1'b1;
        end
      end
      dtas_pkg::ST_SUM: begin
        alu_b = {{(T_W-32){off_r[31]}}, off_r};
        t_nxt = alu_sum;
      end
      dtas_pkg::ST_MOD: begin
        // restoring reduction of the year mod 400
        alu_a   = T_W'(work_r);
        alu_b   = T_W'(dtas_pkg::YEAR_CYCLE) << k_r;
        alu_sub = 1'b1;
        if (!alu_neg) work_nxt = alu_sum[TOD_W-1:0];
        k_nxt = k_r - K_W'(1);
        if (k_r == '0) cal_ctrl.mod_load = 1'b1;
      end
      dtas_pkg::ST_DAY: begin
        alu_b   = T_W'(dtas_pkg::SECS_PER_DAY);
        alu_sub = !t_r[T_W-1];
        if (t_r[T_W-1]) begin
          t_nxt         = alu_sum;
          cal_ctrl.back = 1'b1;
        end else if (!alu_neg) begin
          t_nxt        = alu_sum;
          cal_ctrl.fwd = 1'b1;
        end else begin
          work_nxt = t_r[TOD_W-1:0];
          k_nxt    = dtas_pkg::HOUR_K_FIRST;
        end
      end
      dtas_pkg::ST_HOUR: begin
        alu_a   = T_W'(work_r);
        alu_b   = T_W'(dtas_pkg::SECS_PER_HOUR) << k_r;
        alu_sub = 1'b1;
        if (!alu_neg) work_nxt = alu_sum[TOD_W-1:0];
        hour_nxt = {hour_r[3:0], !alu_neg};
        k_nxt    = (k_r == '0) ? dtas_pkg::MIN_K_FIRST : k_r - K_W'(1);
      end
      dtas_pkg::ST_MIN: begin
        alu_a   = T_W'(work_r);
        alu_b   = T_W'(dtas_pkg::SECS_PER_MIN) << k_r;
        alu_sub = 1'b1;
        if (!alu_neg) work_nxt = alu_sum[TOD_W-1:0];
        min_nxt = {min_r[4:0], !alu_neg};
        k_nxt   = k_r - K_W'(1);
      end
      dtas_pkg::ST_DONE: begin
        out_load = !out_tvalid_r || out_tready;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data               = '0;
    out_data.result_day    = cal_day;
    out_data.result_month  = cal_month;
    out_data.result_year   = cal_year;
    out_data.result_hour   = hour_r;
    out_data.result_minute = min_r;
    out_data.result_second = work_r[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dtas_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    t_r    <= t_nxt;
    off_r  <= off_nxt;
    work_r <= work_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    if (out_load) out_tdata_r <= out_data;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `DTAS_ASSERT_NXT(a_busy_after_transfer, in_tvalid && in_tready, !in_tready)
  `DTAS_ASSERT_IMP(a_day_after_mod, state_r == dtas_pkg::ST_DAY && $past(state_r) == dtas_pkg::ST_MOD, $past(k_r) == '0)
  `DTAS_ASSERT_IMP(a_hour_rem_range, state_r == dtas_pkg::ST_HOUR, work_r < TOD_W'(dtas_pkg::SECS_PER_DAY))
  `DTAS_ASSERT_IMP(a_min_rem_range, state_r == dtas_pkg::ST_MIN, work_r < TOD_W'(dtas_pkg::SECS_PER_HOUR))

endmodule

`default_nettype wire

// File: hdl/dtas_alu.sv
`default_nettype none

module dtas_alu (
  input  wire logic [dtas_pkg::T_W-1:0] a,
  input  wire logic [dtas_pkg::T_W-1:0] b,
  input  wire logic                     sub,
  output logic      [dtas_pkg::T_W-1:0] sum,
  output logic                          neg
);

  always_comb begin
    sum = a + (sub ? ~b : b) + dtas_pkg::T_W'(sub);
    neg = sum[dtas_pkg::T_W-1];
  end

endmodule

`default_nettype wire

// File: hdl/dtas_cal.sv
`default_nettype none

module dtas_cal #(
  parameter logic [31:0] MAX_YEAR = dtas_pkg::MAX_YEAR
) (
  input  wire logic                          clk,
  input  wire dtas_pkg::cal_ctrl_t           ctrl,
  input  wire logic [4:0]                    start_day,
  input  wire logic [3:0]                    start_month,
  input  wire logic [15:0]                   start_year,
  input  wire logic [dtas_pkg::YMOD_W-1:0]   mod_val,
  output logic      [4:0]                    day,
  output logic      [3:0]                    month,
  output logic      [15:0]                   year
);

  logic [4:0]                  day_r, day_nxt;
  logic [3:0]                  month_r, month_nxt;
  logic [dtas_pkg::YEAR_W-1:0] year_r, year_nxt;
  logic [dtas_pkg::YMOD_W-1:0] ymod_r, ymod_nxt;
  logic                        leap;
  logic [5:0]                  day_inc;
  logic [4:0]                  month_inc;

  // year mod 400 tracks the leap rule
  assign leap = (ymod_r[1:0] == 2'd0) && (ymod_r != dtas_pkg::YMOD_C100) &&
                (ymod_r != dtas_pkg::YMOD_C200) && (ymod_r != dtas_pkg::YMOD_C300);

  assign day_inc   = {1'b0, day_r} + 6'd1;
  assign month_inc = {1'b0, month_r} + 5'd1;

  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    ymod_nxt  = ymod_r;
    if (ctrl.load) begin
      day_nxt   = start_day;
      month_nxt = start_month;
      year_nxt  = dtas_pkg::YEAR_W'(start_year);
    end else if (ctrl.mod_load) begin
      ymod_nxt = mod_val;
    end else if (ctrl.fwd) begin
      if (day_inc > {1'b0, dtas_pkg::month_len(month_r, leap)}) begin
        day_nxt = 5'd1;
        if (month_inc > {1'b0, dtas_pkg::MON_DEC}) begin
          month_nxt = dtas_pkg::MON_JAN;
          if (32'(year_r) < MAX_YEAR) begin
            year_nxt = year_r + dtas_pkg::YEAR_W'(1);
            ymod_nxt = (ymod_r == dtas_pkg::YMOD_LAST) ? '0 : ymod_r + dtas_pkg::YMOD_W'(1);
          end
        end else begin
          month_nxt = month_inc[3:0];
        end
      end else begin
        day_nxt = day_inc[4:0];
      end
    end else if (ctrl.back) begin
      if (day_r <= 5'd1) begin
        if (month_r <= dtas_pkg::MON_JAN) begin
          month_nxt = dtas_pkg::MON_DEC;
          // no year before 1
          if (year_r <= dtas_pkg::YEAR_W'(1)) begin
            year_nxt = dtas_pkg::YEAR_W'(1);
            ymod_nxt = dtas_pkg::YMOD_W'(1);
          end else begin
            year_nxt = year_r - dtas_pkg::YEAR_W'(1);
            ymod_nxt = (ymod_r == '0) ? dtas_pkg::YMOD_LAST : ymod_r - dtas_pkg::YMOD_W'(1);
          end
        end else begin
          month_nxt = month_r - 4'd1;
        end
        day_nxt = dtas_pkg::month_len(month_nxt, leap);
      end else begin
        day_nxt = day_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    day_r   <= day_nxt;
    month_r <= month_nxt;
    year_r  <= year_nxt;
    ymod_r  <= ymod_nxt;
  end

  assign day   = day_r;
  assign month = month_r;
  assign year  = year_r[15:0];

endmodule

`default_nettype wire
